/* rtl/alpha_block_sharpness_stats_assert.svh */
// Assertion macros for the alpha block sharpness statistics block.
`ifndef ALPHA_BLOCK_SHARPNESS_STATS_ASSERT_SVH
`define ALPHA_BLOCK_SHARPNESS_STATS_ASSERT_SVH
`ifndef ASSERT_OFF
`define ABSS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define ABSS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ABSS_ASSERT(lbl, cond, msg)
`define ABSS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* rtl/abss_pkg.sv */
// Shared types and constants for the alpha block sharpness statistics block.
`timescale 1ns / 1ps
package abss_pkg;
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int CFG_W          = 13;
	localparam int CFG_IDX_W      = 1;
	localparam int SEMI_W         = 25;
	localparam int BLK_W          = 21;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] EDGE_LO      = 8'd32;
	localparam logic [7:0] EDGE_HI      = 8'd224;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic [4:0] mid;
		logic [4:0] cnt;
	} blk_entry_t;

	typedef struct packed {
		logic first;
		logic close;
		logic last;
	} pos_info_t;
endpackage

/* rtl/abss_pos.sv */
// Raster position tracker: column and row counters and block boundary flags.
`timescale 1ns / 1ps
module abss_pos import abss_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int CW  = $clog2(MAX_WIDTH),
	localparam int BIW = (CW > 3) ? CW - 2 : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [CFG_W-1:0] width_cfg,
	input  logic [CFG_W-1:0] height_cfg,
	output logic [BIW-1:0]   bi,
	output pos_info_t        info
);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WCW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int WCH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [WCW-1:0] w_eff;
	logic [WCH-1:0] h_eff;
	logic           last_col;
	logic           last_row;

	always_comb begin
		if (width_cfg == '0) begin
			w_eff = WCW'(1);
		end else if (WCW'(width_cfg) > WCW'(MAX_WIDTH)) begin
			w_eff = WCW'(MAX_WIDTH);
		end else begin
			w_eff = WCW'(width_cfg);
		end
		if (height_cfg == '0) begin
			h_eff = WCH'(1);
		end else if (WCH'(height_cfg) > WCH'(MAX_HEIGHT)) begin
			h_eff = WCH'(MAX_HEIGHT);
		end else begin
			h_eff = WCH'(height_cfg);
		end
		last_col   = (WCW'(col_q) + WCW'(1)) >= w_eff;
		last_row   = (WCH'(row_q) + WCH'(1)) >= h_eff;
		info.first = (col_q[1:0] == 2'b00) && (row_q[1:0] == 2'b00);
		info.close = ((col_q[1:0] == 2'b11) || last_col) &&
			((row_q[1:0] == 2'b11) || last_row);
		info.last  = last_col && last_row;
		bi         = BIW'(col_q >> 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end
endmodule

/* rtl/abss_blk.sv */
// Block column statistics memory with read-modify-write, forwarding and sharpness test.
`timescale 1ns / 1ps
module abss_blk import abss_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW  = $clog2(MAX_WIDTH),
	localparam int BIW = (CW > 3) ? CW - 2 : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           retire,
	input  logic [BIW-1:0] bi,
	input  logic           first,
	input  logic [7:0]     alpha,
	output logic           sharp
);
	localparam int DEPTH = (MAX_WIDTH + 3) / 4;

	blk_entry_t     mem [DEPTH];
	blk_entry_t     rd_s1;
	blk_entry_t     fwd_s1;
	blk_entry_t     src;
	blk_entry_t     entry_new;
	logic [BIW-1:0] bi_s1;
	logic [7:0]     alpha_s1;
	logic           first_s1;
	logic           hit_s1;
	logic           is_mid;

	always_comb begin
		is_mid = (alpha_s1 > EDGE_LO) && (alpha_s1 < EDGE_HI);
		src    = hit_s1 ? fwd_s1 : rd_s1;
		if (first_s1) begin
			entry_new.lo  = alpha_s1;
			entry_new.hi  = alpha_s1;
			entry_new.mid = 5'(is_mid);
			entry_new.cnt = 5'd1;
		end else begin
			entry_new.lo  = (alpha_s1 < src.lo) ? alpha_s1 : src.lo;
			entry_new.hi  = (alpha_s1 > src.hi) ? alpha_s1 : src.hi;
			entry_new.mid = src.mid + 5'(is_mid);
			entry_new.cnt = src.cnt + 5'd1;
		end
		sharp = (entry_new.lo <= EDGE_LO) && (entry_new.hi >= EDGE_HI) &&
			({entry_new.mid, 2'b00} < {2'b00, entry_new.cnt});
	end

	// read-before-write: a write to the entry read at the same edge is forwarded
	always_ff @(posedge clk) begin
		if (retire) begin
			mem[bi_s1] <= entry_new;
		end
		if (accept) begin
			rd_s1    <= mem[bi];
			fwd_s1   <= entry_new;
			bi_s1    <= bi;
			alpha_s1 <= alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else if (accept) begin
			hit_s1   <= retire && (bi_s1 == bi);
			first_s1 <= first;
		end
	end
endmodule

/* rtl/alpha_block_sharpness_stats.sv */
// Top level of the alpha block sharpness statistics block.
//
//  channel | signals                                         | moves
//  --------+-------------------------------------------------+------------------------
//  in      | in_valid, in_ready, alpha                       | one pixel request
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | one register write
//  out     | out_valid, out_ready, any_transparent,          | one image summary
//          | semi_pixels, sharp_block_count, block_count     |
//
// One pixel per cycle while in_ready is high; two-stage pipe: memory read at accept,
// modify and write in stage 1. Block column memory: one read and one write per cycle,
// stage 1 write forwarded on a hit. Summary is registered as the last pixel leaves stage 1.
// in_ready drops only while a finished summary is held and stage 1 holds another last pixel.
// Reset clears positions and totals; memory entries are written by each block's first pixel.
`timescale 1ns / 1ps
`include "alpha_block_sharpness_stats_assert.svh"
module alpha_block_sharpness_stats import abss_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           alpha,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 any_transparent,
	output logic [SEMI_W-1:0]    semi_pixels,
	output logic [BLK_W-1:0]     sharp_block_count,
	output logic [BLK_W-1:0]     block_count
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int BIW = (CW > 3) ? CW - 2 : 1;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [BIW-1:0]    bi;
	pos_info_t         info;
	pos_info_t         info_s1;
	logic              valid_s1;
	logic              trans_s1;
	logic              semi_s1;
	logic              sharp;
	logic              advance;
	logic              accept;
	logic              retire;
	logic              out_valid_q;
	logic              trans_q;
	logic [SEMI_W-1:0] semi_q;
	logic [BLK_W-1:0]  sharp_q;
	logic [BLK_W-1:0]  blk_q;
	logic              trans_next;
	logic [SEMI_W-1:0] semi_next;
	logic [BLK_W-1:0]  sharp_next;
	logic [BLK_W-1:0]  blk_next;

	assign cfg_ready = 1'b1;
	assign advance   = !(valid_s1 && info_s1.last && out_valid_q && !out_ready);
	assign in_ready  = advance;
	assign accept    = in_valid && in_ready;
	assign retire    = valid_s1 && advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	abss_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.bi         (bi),
		.info       (info)
	);

	abss_blk #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_blk (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.retire (retire),
		.bi     (bi),
		.first  (info.first),
		.alpha  (alpha),
		.sharp  (sharp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			info_s1  <= '0;
			trans_s1 <= 1'b0;
			semi_s1  <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			if (accept) begin
				info_s1  <= info;
				trans_s1 <= alpha != ALPHA_OPAQUE;
				semi_s1  <= (alpha != ALPHA_OPAQUE) && (alpha != 8'd0);
			end
		end
	end

	always_comb begin
		trans_next = trans_q | trans_s1;
		semi_next  = semi_q + SEMI_W'(semi_s1);
		blk_next   = blk_q + BLK_W'(info_s1.close);
		sharp_next = sharp_q + BLK_W'(info_s1.close && sharp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q     <= 1'b0;
			semi_q      <= '0;
			sharp_q     <= '0;
			blk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (retire) begin
				if (info_s1.last) begin
					trans_q <= 1'b0;
					semi_q  <= '0;
					sharp_q <= '0;
					blk_q   <= '0;
				end else begin
					trans_q <= trans_next;
					semi_q  <= semi_next;
					sharp_q <= sharp_next;
					blk_q   <= blk_next;
				end
			end
			if (retire && info_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (retire && info_s1.last) begin
			any_transparent   <= trans_next;
			semi_pixels       <= semi_next;
			sharp_block_count <= sharp_next;
			block_count       <= blk_next;
		end
	end

	`ABSS_ASSERT_IMPL(a_out_free, retire && info_s1.last, !out_valid_q || out_ready, "summary overwritten")
	`ABSS_ASSERT(a_stall_cause, in_ready || (valid_s1 && info_s1.last && out_valid_q), "stall without held summary")
	`ABSS_ASSERT_IMPL(a_out_source, $rose(out_valid_q), $past(retire && info_s1.last), "summary without last pixel")
endmodule

/* dv/alpha_block_sharpness_stats_test.sv */
// Self-checking testbench for the alpha block sharpness statistics block.
`timescale 1ns / 1ps
module alpha_block_sharpness_stats_test;
	import abss_pkg::*;

	localparam int          LIMIT       = 1_500_000;
	localparam int          RAND_PIXELS = 1050;
	localparam int          PLAN_LEN    = 29;
	localparam int          BLOCK_COLS  = (DEF_MAX_WIDTH + 3) / 4;
	localparam logic [CFG_W-1:0] SIZE_ALL_ONES = '1;

	typedef struct packed {
		logic             any_clear;
		logic [SEMI_W-1:0] semi;
		logic [BLK_W-1:0] sharp;
		logic [BLK_W-1:0] blocks;
	} summary_t;

	typedef struct packed {
		bit               is_cfg;
		cfg_reg_t         reg_sel;
		logic [CFG_W-1:0] value;
		logic [7:0]       a;
		bit               typed;
		summary_t         want;
	} plan_row_t;

	typedef enum int unsigned {FILL_OPAQUE, FILL_CUTOUT, FILL_NOISE, FILL_MATTE} fill_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           alpha;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 out_valid;
	logic                 out_ready;
	logic                 any_transparent;
	logic [SEMI_W-1:0]    semi_pixels;
	logic [BLK_W-1:0]     sharp_block_count;
	logic [BLK_W-1:0]     block_count;

	alpha_block_sharpness_stats dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.alpha             (alpha),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.any_transparent   (any_transparent),
		.semi_pixels       (semi_pixels),
		.sharp_block_count (sharp_block_count),
		.block_count       (block_count)
	);

	// predictor state
	logic [CFG_W-1:0]  img_w;
	logic [CFG_W-1:0]  img_h;
	int unsigned       col_pos;
	int unsigned       row_pos;
	logic              saw_clear;
	logic [SEMI_W-1:0] semi_tot;
	logic [BLK_W-1:0]  sharp_tot;
	logic [BLK_W-1:0]  blk_tot;
	blk_entry_t        col_stats [BLOCK_COLS];

	summary_t    summaries [$];
	summary_t    head;
	plan_row_t   plan [PLAN_LEN];
	int unsigned errors;
	int unsigned images_checked;
	int unsigned sharp_images;
	int unsigned pixels_sent;
	int unsigned reg_writes;
	int unsigned resizes;
	int unsigned burst_left;
	int unsigned ready_left;
	int unsigned stall_left;
	int unsigned cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit predict_pixel(input logic [7:0] a, output summary_t res);
		int unsigned w;
		int unsigned h;
		int unsigned bi;
		bit          last_col;
		bit          last_row;
		bit          is_mid;
		blk_entry_t  e;
		w = (img_w == 0) ? 1 : (img_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : img_w;
		h = (img_h == 0) ? 1 : (img_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : img_h;
		res = '0;
		last_col = (col_pos + 1 >= w);
		last_row = (row_pos + 1 >= h);
		bi = col_pos >> 2;
		is_mid = (a > EDGE_LO) && (a < EDGE_HI);
		if (a != ALPHA_OPAQUE) begin
			saw_clear = 1'b1;
			if (a != 8'd0)
				semi_tot++;
		end
		if (col_pos[1:0] == 2'd0 && row_pos[1:0] == 2'd0) begin
			e = '{lo: a, hi: a, mid: 5'(is_mid), cnt: 5'd1};
		end else begin
			e = col_stats[bi];
			if (a < e.lo)
				e.lo = a;
			if (a > e.hi)
				e.hi = a;
			e.mid = e.mid + 5'(is_mid);
			e.cnt = e.cnt + 5'd1;
		end
		col_stats[bi] = e;
		if ((col_pos[1:0] == 2'd3 || last_col) && (row_pos[1:0] == 2'd3 || last_row)) begin
			blk_tot++;
			if (e.lo <= EDGE_LO && e.hi >= EDGE_HI && int'(e.mid) * 4 < int'(e.cnt))
				sharp_tot++;
		end
		if (last_col && last_row) begin
			res = '{any_clear: saw_clear, semi: semi_tot, sharp: sharp_tot, blocks: blk_tot};
			col_pos = 0;
			row_pos = 0;
			saw_clear = 1'b0;
			semi_tot = '0;
			sharp_tot = '0;
			blk_tot = '0;
			return 1'b1;
		end
		if (last_col) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos++;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] pick_alpha(input fill_t fill);
		case (fill)
			FILL_OPAQUE: return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				: ALPHA_OPAQUE;
			FILL_CUTOUT: return $urandom_range(0, 1) ? 8'($urandom_range(0, 32))
				: 8'($urandom_range(224, 255));
			FILL_NOISE:  return 8'($urandom_range(0, 255));
			default:     return ($urandom_range(0, 5) == 0) ? 8'($urandom_range(33, 223))
				: ($urandom_range(0, 1) ? 8'd0 : ALPHA_OPAQUE);
		endcase
	endfunction

	function automatic plan_row_t px(input logic [7:0] a);
		px = '0;
		px.a = a;
	endfunction

	function automatic plan_row_t px_then(input logic [7:0] a, input logic any_clear,
		input int unsigned semi, input int unsigned sharp, input int unsigned blocks);
		px_then = px(a);
		px_then.typed = 1'b1;
		px_then.want = '{any_clear: any_clear, semi: SEMI_W'(semi), sharp: BLK_W'(sharp),
			blocks: BLK_W'(blocks)};
	endfunction

	function automatic plan_row_t reg_row(input cfg_reg_t sel, input logic [CFG_W-1:0] v);
		reg_row = '0;
		reg_row.is_cfg = 1'b1;
		reg_row.reg_sel = sel;
		reg_row.value = v;
	endfunction

	// drop the request and wait until the pipe has emptied
	task automatic wait_idle();
		in_valid = 1'b0;
		while (summaries.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] v);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = sel;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			CFG_IMAGE_WIDTH:  img_w = v;
			CFG_IMAGE_HEIGHT: img_h = v;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// called at a falling edge; leaves the request raised for a following pixel
	task automatic send_pixel(input logic [7:0] a, input bit typed, input summary_t typed_want,
		output bit done);
		summary_t res;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
		end
		burst_left--;
		in_valid = 1'b1;
		alpha = a;
		do @(posedge clk); while (!in_ready);
		done = predict_pixel(a, res);
		if (done)
			summaries.insert(summaries.size(), typed ? typed_want : res);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// receiver: ready stretches alternating with stalls of random length
	always @(negedge clk) begin
		if (ready_left != 0) begin
			ready_left--;
			out_ready = 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_ready = 1'b0;
		end else begin
			ready_left = $urandom_range(1, 24);
			stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (summaries.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("summary with none outstanding: %0d %0d %0d %0d",
						any_transparent, semi_pixels, sharp_block_count, block_count);
			end else begin
				head = summaries.pop_front();
				check_field("any_transparent", head.any_clear, any_transparent);
				check_field("semi_pixels", head.semi, semi_pixels);
				check_field("sharp_block_count", head.sharp, sharp_block_count);
				check_field("block_count", head.blocks, block_count);
				images_checked++;
				if (head.sharp != 0)
					sharp_images++;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run exceeded %0d cycles with %0d summaries outstanding", LIMIT,
			summaries.size());
		$display("FAIL alpha_block_sharpness_stats");
		$finish;
	end

	initial begin
		int unsigned rand_pixels;
		int unsigned n;
		int unsigned cut;
		int unsigned sent;
		bit          done;
		fill_t       fill;
		arst_n = 1'b0;
		in_valid = 1'b0;
		alpha = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		out_ready = 1'b0;
		ready_left = 0;
		stall_left = 0;
		burst_left = 0;
		errors = 0;
		images_checked = 0;
		sharp_images = 0;
		pixels_sent = 0;
		reg_writes = 0;
		resizes = 0;
		rand_pixels = 0;
		img_w = CFG_W'(1);
		img_h = CFG_W'(1);
		col_pos = 0;
		row_pos = 0;
		saw_clear = 1'b0;
		semi_tot = '0;
		sharp_tot = '0;
		blk_tot = '0;
		plan = '{
			px_then(8'd255, 1'b0, 0, 0, 1),
			px_then(8'd0, 1'b1, 0, 0, 1),
			px_then(8'd128, 1'b1, 1, 0, 1),
			reg_row(CFG_IMAGE_WIDTH, '0),
			reg_row(CFG_IMAGE_HEIGHT, '0),
			px_then(8'd254, 1'b1, 1, 0, 1),
			reg_row(CFG_IMAGE_WIDTH, CFG_W'(2)),
			reg_row(CFG_IMAGE_HEIGHT, CFG_W'(1)),
			px(8'd0),
			px_then(8'd255, 1'b1, 0, 1, 1),
			reg_row(CFG_IMAGE_WIDTH, CFG_W'(4)),
			px(8'd32), px(8'd224), px(8'd255),
			px_then(8'd255, 1'b1, 2, 1, 1),
			reg_row(CFG_IMAGE_WIDTH, CFG_W'(2)),
			px(8'd33),
			px_then(8'd223, 1'b1, 2, 0, 1),
			reg_row(CFG_IMAGE_HEIGHT, CFG_W'(2)),
			px(8'd0), px(8'd255), px(8'd255),
			px_then(8'd40, 1'b1, 1, 0, 1),
			// shrink the width part way through the first row
			reg_row(CFG_IMAGE_WIDTH, CFG_W'(3)),
			px(8'd10), px(8'd20),
			reg_row(CFG_IMAGE_WIDTH, CFG_W'(1)),
			px(8'd30), px(8'd250)
		};
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].reg_sel, plan[i].value);
			else
				send_pixel(plan[i].a, plan[i].typed, plan[i].want, done);
		end

		// one row as wide as the widest random image fills every block column entry in use
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(48));
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(1));
		do send_pixel(pick_alpha(FILL_CUTOUT), 1'b0, '0, done); while (!done);

		// oversized registers saturate; a shrink part way through closes the image early
		write_reg(CFG_IMAGE_WIDTH, SIZE_ALL_ONES);
		repeat (8) send_pixel(pick_alpha(FILL_NOISE), 1'b0, '0, done);
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(1));
		do send_pixel(pick_alpha(FILL_CUTOUT), 1'b0, '0, done); while (!done);
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(2));
		write_reg(CFG_IMAGE_HEIGHT, SIZE_ALL_ONES);
		repeat (6) send_pixel(pick_alpha(FILL_MATTE), 1'b0, '0, done);
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(1));
		do send_pixel(pick_alpha(FILL_MATTE), 1'b0, '0, done); while (!done);

		while (rand_pixels < RAND_PIXELS) begin
			if ($urandom_range(0, 1))
				write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 7) == 0)
					? CFG_W'($urandom_range(17, 48)) : CFG_W'($urandom_range(0, 16)));
			if ($urandom_range(0, 1))
				write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 7) == 0)
					? CFG_W'($urandom_range(10, 20)) : CFG_W'($urandom_range(0, 9)));
			fill = fill_t'($urandom_range(0, 3));
			n = ((img_w == 0) ? 1 : img_w) * ((img_h == 0) ? 1 : img_h);
			cut = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : 0;
			sent = 0;
			do begin
				if (cut != 0 && sent == cut) begin
					write_reg(cfg_reg_t'($urandom_range(0, 1)), CFG_W'($urandom_range(1, 20)));
					resizes++;
				end
				send_pixel(pick_alpha(fill), 1'b0, '0, done);
				sent++;
				rand_pixels++;
			end while (!done);
		end

		in_valid = 1'b0;
		while (summaries.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		$display("%0d pixels sent, %0d image summaries checked, %0d with sharp blocks",
			pixels_sent, images_checked, sharp_images);
		$display("%0d register writes incl. %0d mid-image resizes; %0d mismatches",
			reg_writes, resizes, errors);
		if (errors == 0)
			$display("PASS alpha_block_sharpness_stats");
		else
			$display("FAIL alpha_block_sharpness_stats");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/abss_pkg.sv
rtl/abss_pos.sv
rtl/abss_blk.sv
rtl/alpha_block_sharpness_stats.sv
dv/alpha_block_sharpness_stats_test.sv
